// ----- hw/rtl/pblm_pkg.sv -----
// Shared constants, codes and stage types of the pixel binning and table map block.
`default_nettype none

package pblm_pkg;

    // Sizing
    localparam int MAX_ROW_WIDTH = 4096;
    localparam int PIXEL_BITS    = 16;
    localparam int TABLE_DEPTH   = 65536;
    localparam int ROW_LIMIT     = 4096;

    localparam int COL_DEPTH = MAX_ROW_WIDTH / 2;
    localparam int COL_IW    = $clog2(MAX_ROW_WIDTH);
    localparam int COL_AW    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
    localparam int ROW_IW    = $clog2(ROW_LIMIT);
    localparam int TABLE_AW  = $clog2(TABLE_DEPTH);

    // Field and register widths
    localparam int PIXEL_W  = 16;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int BIN_W    = 3;
    localparam int DIM_W    = 13;
    localparam int CFG_IW   = 4;
    localparam int ROWSUM_W = 18;
    localparam int COLSUM_W = 20;

    // Width for comparisons of indexes against the clamped dimensions
    localparam int XW = ((DIM_W > COL_IW) ? DIM_W : COL_IW) + 1;

    // Divide a column index by three: multiply by a rounded-up reciprocal
    localparam int DIV3_SHIFT = COL_IW + 1;
    localparam int DIV3_MULT  = ((2 ** DIV3_SHIFT) + 2) / 3;

    // Divide a block sum by nine the same way
    localparam int DIV9_SHIFT = 23;
    localparam int DIV9_MULT  = ((2 ** DIV9_SHIFT) + 8) / 9;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IW-1:0] {
        CFG_BIN_FACTOR = 4'd0,
        CFG_PICK_MODE  = 4'd1,
        CFG_ROW_WIDTH  = 4'd2,
        CFG_ROW_COUNT  = 4'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        S1_TWRITE,
        S1_PICK,
        S1_CSUM
    } s1_op_t;

    typedef enum logic {
        MAP_WRITE,
        MAP_LOOKUP
    } map_op_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_BY_4,
        DIV_BY_9,
        DIV_BY_16
    } div_sel_t;

    typedef struct packed {
        logic              en;
        logic [COL_AW-1:0] addr;
    } csum_rd_t;

    typedef struct packed {
        logic                valid;
        s1_op_t              op;
        logic [ROWSUM_W-1:0] value;
        logic [DATA_W-1:0]   data;
        logic [COL_AW-1:0]   bc;
        logic                accum;
        logic                emit;
        div_sel_t            div_sel;
        logic                row_end;
        logic                frame_end;
    } s1_t;

    typedef struct packed {
        logic                valid;
        map_op_t             op;
        logic [COLSUM_W-1:0] value;
        logic [DATA_W-1:0]   data;
        div_sel_t            div_sel;
        logic                row_end;
        logic                frame_end;
    } s2_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              row_end;
        logic              frame_end;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pixel_bin_and_lut_map.sv -----
// Top level of the pixel binning downsampler with 8-bit table map.
//
// The block reduces a row-major stream of 16-bit pixels by a bin factor B of
// 2, 3 or 4 and maps every reduced value through a 64K x 8 lookup table.
// Average mode sums each BxB block, takes floor(sum / B*B) and drops partial
// blocks; pick mode takes the top-left pixel of each block and keeps partial
// blocks. Items with req_type = 1 load one table entry and give no result.
// The block takes one item per clock while req_stall is low; a result passes
// through the scan stage, the column sum read-modify-write, the divide and
// table read and the result queue. The column sum store (2048 x 20) and the table
// (65536 x 8) are dual-port memories with registered reads; neither has a
// clearing pass, so the block accepts items from the first cycle after reset.
// Table entries must be written before any pixel maps through them.
// An eight-entry result queue separates the two channels: req_stall rises only
// when the queue plus the results still in the pipeline fill it, so a waiting
// result does not hold up the input until the queue is nearly full.
// Write configuration only while no item is in flight; cfg_ready is always high.
`default_nettype none

module pixel_bin_and_lut_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pblm_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [pblm_pkg::DIM_W-1:0]    cfg_data,
    // input items
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          req_type,
    input  wire logic [pblm_pkg::PIXEL_W-1:0]  pixel,
    input  wire logic [pblm_pkg::ADDR_W-1:0]   table_addr,
    input  wire logic [pblm_pkg::DATA_W-1:0]   table_data,
    // result items
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic [pblm_pkg::DATA_W-1:0]        out_pixel,
    output logic                               row_end,
    output logic                               frame_end
);

    pblm_pkg::csum_rd_t csum_rd;
    pblm_pkg::s1_t      s1;
    pblm_pkg::s2_t      s2;
    pblm_pkg::result_t  s3;
    pblm_pkg::result_t  head;
    logic               s3_valid;
    logic               s1_res;
    logic               s2_res;
    logic [1:0]         inflight;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // Stage 1: frame counters, configuration, column sum fetch
    pblm_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .pixel      (pixel),
        .table_addr (table_addr),
        .table_data (table_data),
        .csum_rd    (csum_rd),
        .s1         (s1)
    );

    // Stage 2: add the block row into its column sum and write it back
    pblm_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .csum_rd (csum_rd),
        .s1      (s1),
        .s2      (s2)
    );

    // Stage 3: divide by the block area, then read or write the table
    pblm_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2       (s2),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    // Count the results already committed in the pipeline
    assign s1_res = s1.valid
                    && ((s1.op == pblm_pkg::S1_PICK)
                        || ((s1.op == pblm_pkg::S1_CSUM) && s1.emit));
    assign s2_res = s2.valid && (s2.op == pblm_pkg::MAP_LOOKUP);
    assign inflight = {1'b0, s1_res} + {1'b0, s2_res} + {1'b0, s3_valid};

    pblm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid),
        .push_data (s3),
        .inflight  (inflight),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .head      (head),
        .req_stall (req_stall)
    );

    assign out_pixel = head.value;
    assign row_end   = head.row_end;
    assign frame_end = head.frame_end;

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pblm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_scan.sv -----
// Configuration registers, frame position counters and first pipeline stage.
`default_nettype none

module pblm_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [pblm_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [pblm_pkg::DIM_W-1:0]    cfg_data,
    input  wire logic                          req_valid,
    input  wire logic                          req_stall,
    input  wire logic                          req_type,
    input  wire logic [pblm_pkg::PIXEL_W-1:0]  pixel,
    input  wire logic [pblm_pkg::ADDR_W-1:0]   table_addr,
    input  wire logic [pblm_pkg::DATA_W-1:0]   table_data,
    output pblm_pkg::csum_rd_t                 csum_rd,
    output pblm_pkg::s1_t                      s1
);

    logic [pblm_pkg::BIN_W-1:0]    bin_factor_reg;
    logic                          pick_mode_reg;
    logic [pblm_pkg::DIM_W-1:0]    row_width_reg;
    logic [pblm_pkg::DIM_W-1:0]    row_count_reg;

    logic [pblm_pkg::ROWSUM_W-1:0] brs_reg,          brs_next;
    logic [pblm_pkg::COL_IW-1:0]   column_index_reg, column_index_next;
    logic [pblm_pkg::ROW_IW-1:0]   row_index_reg,    row_index_next;
    logic [1:0]                    column_phase_reg, column_phase_next;
    logic [1:0]                    row_phase_reg,    row_phase_next;
    pblm_pkg::s1_t                 s1_reg,           s1_next;

    logic [pblm_pkg::BIN_W-1:0]    b;
    logic [1:0]                    b_m1;
    logic [pblm_pkg::XW-1:0]       w;
    logic [pblm_pkg::XW-1:0]       h;
    logic [pblm_pkg::ROWSUM_W-1:0] pix_ext;
    logic [pblm_pkg::ROWSUM_W-1:0] brs_sum;
    logic                          accept;
    logic                          pix_acc;
    logic                          at_col_end;
    logic                          blk_row_end;
    logic                          blk_frame_end;
    logic                          last_col;
    logic                          last_row;
    logic [2*pblm_pkg::COL_IW-1:0] prod3;
    logic [pblm_pkg::COL_AW-1:0]   bc;
    pblm_pkg::div_sel_t            div_sel;

    // Clamp the configuration to its legal ranges
    always_comb
    begin
        if (bin_factor_reg < 3'd2)
        begin
            b = 3'd2;
        end
        else if (bin_factor_reg > 3'd4)
        begin
            b = 3'd4;
        end
        else
        begin
            b = bin_factor_reg;
        end

        if (row_width_reg == '0)
        begin
            w = pblm_pkg::XW'(1);
        end
        else if (pblm_pkg::XW'(row_width_reg) > pblm_pkg::XW'(pblm_pkg::MAX_ROW_WIDTH))
        begin
            w = pblm_pkg::XW'(pblm_pkg::MAX_ROW_WIDTH);
        end
        else
        begin
            w = pblm_pkg::XW'(row_width_reg);
        end

        if (row_count_reg == '0)
        begin
            h = pblm_pkg::XW'(1);
        end
        else if (pblm_pkg::XW'(row_count_reg) > pblm_pkg::XW'(pblm_pkg::ROW_LIMIT))
        begin
            h = pblm_pkg::XW'(pblm_pkg::ROW_LIMIT);
        end
        else
        begin
            h = pblm_pkg::XW'(row_count_reg);
        end
    end

    assign b_m1     = 2'(b - 3'd1);
    assign pix_ext  = pblm_pkg::ROWSUM_W'(pixel[pblm_pkg::PIXEL_BITS-1:0]);
    assign brs_sum  = brs_reg + pix_ext;
    assign accept   = req_valid && !req_stall;
    assign pix_acc  = accept && !req_type;

    assign at_col_end    = (column_phase_reg == b_m1);
    assign blk_row_end   = (pblm_pkg::XW'(column_index_reg) + pblm_pkg::XW'(b)) >= w;
    assign blk_frame_end = blk_row_end
                           && ((pblm_pkg::XW'(row_index_reg) + pblm_pkg::XW'(b)) >= h);
    assign last_col      = pblm_pkg::XW'(column_index_reg) >= (w - pblm_pkg::XW'(1));
    assign last_row      = pblm_pkg::XW'(row_index_reg) >= (h - pblm_pkg::XW'(1));

    // Block column of the current pixel
    assign prod3 = (2 * pblm_pkg::COL_IW)'(column_index_reg)
                   * (2 * pblm_pkg::COL_IW)'(pblm_pkg::DIV3_MULT);

    always_comb
    begin
        case (b)
            3'd2:
            begin
                bc      = pblm_pkg::COL_AW'(column_index_reg >> 1);
                div_sel = pblm_pkg::DIV_BY_4;
            end
            3'd3:
            begin
                bc      = pblm_pkg::COL_AW'(prod3 >> pblm_pkg::DIV3_SHIFT);
                div_sel = pblm_pkg::DIV_BY_9;
            end
            default:
            begin
                bc      = pblm_pkg::COL_AW'(column_index_reg >> 2);
                div_sel = pblm_pkg::DIV_BY_16;
            end
        endcase
    end

    // Fetch the stored column sum for a block row that adds to an earlier one
    assign csum_rd.en   = pix_acc && !pick_mode_reg && at_col_end && (row_phase_reg != 2'd0);
    assign csum_rd.addr = bc;

    // Work to carry into the next stage
    always_comb
    begin
        s1_next           = '0;
        s1_next.op        = pblm_pkg::S1_TWRITE;
        s1_next.div_sel   = pblm_pkg::DIV_NONE;
        s1_next.row_end   = blk_row_end;
        s1_next.frame_end = blk_frame_end;
        s1_next.bc        = bc;
        s1_next.data      = table_data;
        if (accept && req_type)
        begin
            s1_next.valid = 1'b1;
            s1_next.value = pblm_pkg::ROWSUM_W'(table_addr);
        end
        else if (pix_acc && pick_mode_reg)
        begin
            s1_next.valid = (column_phase_reg == 2'd0) && (row_phase_reg == 2'd0);
            s1_next.op    = pblm_pkg::S1_PICK;
            s1_next.value = pix_ext;
        end
        else if (pix_acc && at_col_end)
        begin
            s1_next.valid   = 1'b1;
            s1_next.op      = pblm_pkg::S1_CSUM;
            s1_next.value   = brs_sum;
            s1_next.accum   = (row_phase_reg != 2'd0);
            s1_next.emit    = (row_phase_reg == b_m1);
            s1_next.div_sel = div_sel;
        end
    end

    // Advance the frame position
    always_comb
    begin
        brs_next          = brs_reg;
        column_index_next = column_index_reg;
        row_index_next    = row_index_reg;
        column_phase_next = column_phase_reg;
        row_phase_next    = row_phase_reg;
        if (pix_acc)
        begin
            if (!pick_mode_reg)
            begin
                brs_next = brs_sum;
            end
            if (column_phase_reg >= b_m1)
            begin
                column_phase_next = 2'd0;
                brs_next          = '0;
            end
            else
            begin
                column_phase_next = column_phase_reg + 2'd1;
            end

            if (last_col)
            begin
                column_index_next = '0;
                column_phase_next = 2'd0;
                brs_next          = '0;
                if (last_row)
                begin
                    row_index_next = '0;
                    row_phase_next = 2'd0;
                end
                else
                begin
                    row_index_next = row_index_reg + pblm_pkg::ROW_IW'(1);
                    if (row_phase_reg >= b_m1)
                    begin
                        row_phase_next = 2'd0;
                    end
                    else
                    begin
                        row_phase_next = row_phase_reg + 2'd1;
                    end
                end
            end
            else
            begin
                column_index_next = column_index_reg + pblm_pkg::COL_IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_factor_reg   <= 3'd2;
            pick_mode_reg    <= 1'b0;
            row_width_reg    <= pblm_pkg::DIM_W'(4096);
            row_count_reg    <= pblm_pkg::DIM_W'(4096);
            brs_reg          <= '0;
            column_index_reg <= '0;
            row_index_reg    <= '0;
            column_phase_reg <= 2'd0;
            row_phase_reg    <= 2'd0;
            s1_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pblm_pkg::CFG_BIN_FACTOR: bin_factor_reg <= cfg_data[pblm_pkg::BIN_W-1:0];
                    pblm_pkg::CFG_PICK_MODE:  pick_mode_reg  <= cfg_data[0];
                    pblm_pkg::CFG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                    pblm_pkg::CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
            brs_reg          <= brs_next;
            column_index_reg <= column_index_next;
            row_index_reg    <= row_index_next;
            column_phase_reg <= column_phase_next;
            row_phase_reg    <= row_phase_next;
            s1_reg           <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_accum.sv -----
// Column sum store: read-modify-write of block column sums, second pipeline stage.
`default_nettype none

module pblm_accum (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pblm_pkg::csum_rd_t csum_rd,
    input  wire pblm_pkg::s1_t  s1,
    output pblm_pkg::s2_t       s2
);

    logic [pblm_pkg::COLSUM_W-1:0] rdata;
    logic [pblm_pkg::COLSUM_W-1:0] brs_ext;
    logic [pblm_pkg::COLSUM_W-1:0] sum;
    logic                          csum_we;
    pblm_pkg::s2_t                 s2_reg, s2_next;

    pblm_ram #(
        .WIDTH (pblm_pkg::COLSUM_W),
        .DEPTH (pblm_pkg::COL_DEPTH)
    ) u_csum_ram (
        .clk   (clk),
        .we    (csum_we),
        .waddr (s1.bc),
        .wdata (sum),
        .re    (csum_rd.en),
        .raddr (csum_rd.addr),
        .rdata (rdata)
    );

    assign brs_ext = pblm_pkg::COLSUM_W'(s1.value);
    assign sum     = s1.accum ? (rdata + brs_ext) : brs_ext;
    assign csum_we = s1.valid && (s1.op == pblm_pkg::S1_CSUM);

    always_comb
    begin
        s2_next           = '0;
        s2_next.value     = brs_ext;
        s2_next.data      = s1.data;
        s2_next.div_sel   = s1.div_sel;
        s2_next.row_end   = s1.row_end;
        s2_next.frame_end = s1.frame_end;
        case (s1.op)
            pblm_pkg::S1_TWRITE:
            begin
                s2_next.valid = s1.valid;
                s2_next.op    = pblm_pkg::MAP_WRITE;
            end
            pblm_pkg::S1_PICK:
            begin
                s2_next.valid = s1.valid;
                s2_next.op    = pblm_pkg::MAP_LOOKUP;
            end
            pblm_pkg::S1_CSUM:
            begin
                // Only the last block row of a block yields a result
                s2_next.valid = s1.valid && s1.emit;
                s2_next.op    = pblm_pkg::MAP_LOOKUP;
                s2_next.value = sum;
            end
            default:
            begin
                s2_next.valid = 1'b0;
                s2_next.op    = pblm_pkg::MAP_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_map.sv -----
// Block average divide and lookup table access, third pipeline stage.
`default_nettype none

module pblm_map (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pblm_pkg::s2_t s2,
    output logic               s3_valid,
    output pblm_pkg::result_t  s3
);

    logic [2*pblm_pkg::COLSUM_W-1:0] prod9;
    logic [pblm_pkg::COLSUM_W-1:0]   quot;
    logic                            tbl_we;
    logic                            tbl_re;
    logic [pblm_pkg::DATA_W-1:0]     tbl_rdata;
    logic                            s3_valid_reg;
    logic                            row_end_reg;
    logic                            frame_end_reg;

    assign prod9 = (2 * pblm_pkg::COLSUM_W)'(s2.value)
                   * (2 * pblm_pkg::COLSUM_W)'(pblm_pkg::DIV9_MULT);

    // Floor of the block sum over the block area; other items pass their value unchanged
    always_comb
    begin
        case (s2.div_sel)
            pblm_pkg::DIV_NONE:  quot = s2.value;
            pblm_pkg::DIV_BY_4:  quot = s2.value >> 2;
            pblm_pkg::DIV_BY_9:  quot = pblm_pkg::COLSUM_W'(prod9 >> pblm_pkg::DIV9_SHIFT);
            pblm_pkg::DIV_BY_16: quot = s2.value >> 4;
            default:             quot = s2.value;
        endcase
    end

    assign tbl_we = s2.valid && (s2.op == pblm_pkg::MAP_WRITE);
    assign tbl_re = s2.valid && (s2.op == pblm_pkg::MAP_LOOKUP);

    pblm_ram #(
        .WIDTH (pblm_pkg::DATA_W),
        .DEPTH (pblm_pkg::TABLE_DEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s2.value[pblm_pkg::TABLE_AW-1:0]),
        .wdata (s2.data),
        .re    (tbl_re),
        .raddr (quot[pblm_pkg::TABLE_AW-1:0]),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            row_end_reg   <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= tbl_re;
            row_end_reg   <= s2.row_end;
            frame_end_reg <= s2.frame_end;
        end
    end

    assign s3_valid     = s3_valid_reg;
    assign s3.value     = tbl_rdata;
    assign s3.row_end   = row_end_reg;
    assign s3.frame_end = frame_end_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_fifo.sv -----
// Result queue with credit-based input stall.
`default_nettype none

module pblm_fifo (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire pblm_pkg::result_t            push_data,
    input  wire logic [1:0]                   inflight,
    input  wire logic                         res_stall,
    output logic                              res_valid,
    output pblm_pkg::result_t                 head,
    output logic                              req_stall
);

    pblm_pkg::result_t               mem_reg [pblm_pkg::FIFO_DEPTH];
    logic [pblm_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pblm_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pblm_pkg::FIFO_AW:0]      count_reg,  count_next;
    logic                            pop;
    logic [pblm_pkg::FIFO_AW+1:0]    committed;

    assign res_valid = (count_reg != '0);
    assign pop       = res_valid && !res_stall;
    assign head      = mem_reg[rd_ptr_reg];

    // Hold the input while the queue could not absorb every result in flight
    assign committed = (pblm_pkg::FIFO_AW + 2)'(count_reg) + (pblm_pkg::FIFO_AW + 2)'(inflight);
    assign req_stall = committed >= (pblm_pkg::FIFO_AW + 2)'(pblm_pkg::FIFO_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + pblm_pkg::FIFO_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + pblm_pkg::FIFO_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (pblm_pkg::FIFO_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (pblm_pkg::FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pblm_checker.sv -----
// Port-level checker for the pixel binning and table map block, with its bind.
`default_nettype none

module pblm_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_stall,
    input wire logic                         req_type,
    input wire logic                         res_valid,
    input wire logic                         res_stall,
    input wire logic [pblm_pkg::DATA_W-1:0]  out_pixel,
    input wire logic                         row_end,
    input wire logic                         frame_end
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(out_pixel) && $stable(row_end) && $stable(frame_end))
        else $error("stalled result changed");

    // The last output of a frame also closes its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // Input stalls only while the result queue holds items
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid)
        else $error("input stalled with an empty result queue");

    // A result that appears on an empty output comes from an accepted pixel item
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && !req_stall && !req_type, 4))
        else $error("result without a matching pixel item");

endmodule

bind pixel_bin_and_lut_map pblm_checker u_pblm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_pixel (out_pixel),
    .row_end   (row_end),
    .frame_end (frame_end)
);

`default_nettype wire

// ----- test/pixel_bin_and_lut_map_tb.sv -----
// Self-checking testbench for the pixel binning downsampler with table map.
module pixel_bin_and_lut_map_tb;

    import pblm_pkg::*;

    // Run control
    localparam int LIMIT_CYCLES   = 2_000_000;
    localparam int PIPE_SLACK     = 16;    // leave ample room for the pipe to drain
    localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off, far beyond the queue depth
    localparam int RANDOM_ITEMS   = 250;
    localparam int REPORT_LINES   = 40;

    // Pixel values come from a few narrow windows of table entries; a block average
    // of values in one window stays in that window
    localparam int WIN_COUNT = 4;
    localparam int WIN_SPAN  = 8;

    // One input item as the driver puts it on the bus
    typedef struct packed {
        logic        req_type;
        logic [15:0] pixel;
        logic [15:0] table_addr;
        logic [7:0]  table_data;
    } feed_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic                 req_type = 1'b0;
    logic [PIXEL_W-1:0]   pixel = '0;
    logic [ADDR_W-1:0]    table_addr = '0;
    logic [DATA_W-1:0]    table_data = '0;

    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [DATA_W-1:0]    out_pixel;
    logic                 row_end;
    logic                 frame_end;

    // Items waiting to be offered, and reduced pixels waiting to come out
    feed_item_t pixel_feed[$];
    result_t    binned_due[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Table windows the pixels are drawn from, and the one an average phase uses
    logic [15:0] win_base [WIN_COUNT];
    int          cur_win = 0;

    // Predictor state: configuration as written, table, column sums, scan counters
    logic [2:0]          cfg_bin   = 3'd2;
    logic                cfg_pick  = 1'b0;
    logic [DIM_W-1:0]    cfg_width = 13'd4096;
    logic [DIM_W-1:0]    cfg_rows  = 13'd4096;
    logic [7:0]          lut_model [TABLE_DEPTH];
    logic [COLSUM_W-1:0] csum_model [COL_DEPTH];
    logic [ROWSUM_W-1:0] brow_sum = '0;
    logic [11:0]         col_idx = '0;
    logic [11:0]         row_idx = '0;
    logic [1:0]          col_ph = '0;
    logic [1:0]          row_ph = '0;

    // Driver and receiver pacing
    feed_item_t on_bus;
    bit  taken;
    int  gap_left = 0;
    int  calm_left = 0;
    bit  no_gaps = 1'b0;
    int  stall_left = 0;
    int  flow_left = 0;
    int  squeeze_left = 0;
    int  squeeze_reqs = 0;
    int  squeeze_done = 0;
    result_t want;

    pixel_bin_and_lut_map DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .pixel      (pixel),
        .table_addr (table_addr),
        .table_data (table_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_pixel  (out_pixel),
        .row_end    (row_end),
        .frame_end  (frame_end)
    );

    always #4 clk = ~clk;

    // Watchdog: end the run if the block hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Block edge, row width and row count after the block's clamping
    function automatic int eff_bin();
        if (cfg_bin < 3'd2)
            return 2;
        else if (cfg_bin > 3'd4)
            return 4;
        else
            return int'(cfg_bin);
    endfunction

    function automatic int eff_width();
        if (cfg_width < 13'd1)
            return 1;
        else if (cfg_width > MAX_ROW_WIDTH)
            return MAX_ROW_WIDTH;
        else
            return int'(cfg_width);
    endfunction

    function automatic int eff_rows();
        if (cfg_rows < 13'd1)
            return 1;
        else if (cfg_rows > ROW_LIMIT)
            return ROW_LIMIT;
        else
            return int'(cfg_rows);
    endfunction

    // Advance the predicted scan by one accepted item and queue the reduced pixel it yields
    task automatic predict_binned(input feed_item_t it);
        int b;
        int w;
        int h;
        int bc;
        int col;
        int row;
        bit emit;
        result_t r;
        if (it.req_type) begin
            // table load: store only, counters untouched
            lut_model[it.table_addr] = it.table_data;
        end else begin
            b = eff_bin();
            w = eff_width();
            h = eff_rows();
            col = int'(col_idx);
            row = int'(row_idx);
            emit = 1'b0;
            r = '0;
            if (cfg_pick) begin
                // top-left pixel of each block, partial blocks kept
                if (col_ph == 2'd0 && row_ph == 2'd0) begin
                    emit = 1'b1;
                    r.value = lut_model[it.pixel];
                end
            end else begin
                brow_sum = brow_sum + it.pixel;
                if (col_ph == b - 1) begin
                    bc = (col / b) % COL_DEPTH;
                    if (row_ph == 2'd0)
                        csum_model[bc] = COLSUM_W'(brow_sum);
                    else
                        csum_model[bc] = csum_model[bc] + brow_sum;
                    if (row_ph == b - 1) begin
                        emit = 1'b1;
                        r.value = lut_model[csum_model[bc] / (b * b)];
                    end
                end
            end
            if (emit) begin
                r.row_end = (col + b >= w);
                r.frame_end = r.row_end && (row + b >= h);
                binned_due.push_back(r);
            end
            // step the phases; a phase at or past the block edge wraps
            if (col_ph >= b - 1) begin
                col_ph = '0;
                brow_sum = '0;
            end else begin
                col_ph++;
            end
            if (col >= w - 1) begin
                col_idx = '0;
                col_ph = '0;
                brow_sum = '0;
                if (row >= h - 1) begin
                    row_idx = '0;
                    row_ph = '0;
                end else begin
                    row_idx++;
                    if (row_ph >= b - 1)
                        row_ph = '0;
                    else
                        row_ph++;
                end
            end else begin
                col_idx++;
            end
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Driver: hold a stalled item, predict on acceptance, then pace the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            taken = req_valid && !req_stall;
            if (taken)
                predict_binned(on_bus);
            if (taken || !req_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (pixel_feed.size() > 0) begin
                    on_bus = pixel_feed.pop_front();
                    req_type   <= on_bus.req_type;
                    pixel      <= on_bus.pixel;
                    table_addr <= on_bus.table_addr;
                    table_data <= on_bus.table_data;
                    req_valid  <= 1'b1;
                    // mostly short gaps, some long ones, and stretches with none
                    if (no_gaps) begin
                        gap_left = 0;
                    end else if (calm_left > 0) begin
                        calm_left--;
                        gap_left = 0;
                    end else if ($urandom_range(0, 99) < 3) begin
                        calm_left = $urandom_range(30, 150);
                        gap_left = 0;
                    end else begin
                        gap_left = ($urandom_range(0, 99) < 50) ? 0 : idle_len();
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        if (mismatch_count < REPORT_LINES)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Monitor: check each accepted result against the oldest prediction, then pace res_stall
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (binned_due.size() == 0) begin
                report_mismatch("result with nothing expected, out_pixel", out_pixel, 8'h00);
            end else begin
                want = binned_due.pop_front();
                if (out_pixel !== want.value)
                    report_mismatch("out_pixel", out_pixel, want.value);
                if (row_end !== want.row_end)
                    report_mismatch("row_end", row_end, want.row_end);
                if (frame_end !== want.frame_end)
                    report_mismatch("frame_end", frame_end, want.frame_end);
            end
        end
        // a requested squeeze overrides the random pattern so the input side backs up
        if (squeeze_left > 0) begin
            squeeze_left--;
            res_stall <= 1'b1;
        end else if (squeeze_done < squeeze_reqs) begin
            squeeze_done++;
            squeeze_left = SQUEEZE_CYCLES - 1;
            res_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            res_stall <= 1'b1;
        end else if (flow_left > 0) begin
            flow_left--;
            res_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 45)
                flow_left = $urandom_range(1, 40);
            else
                stall_left = idle_len();
            res_stall <= 1'b0;
        end
    end

    // A value somewhere inside one table window
    function automatic logic [15:0] win_value(input int k);
        return win_base[k] + 16'($urandom_range(0, WIN_SPAN - 1));
    endfunction

    // Pick mode may mix windows; an average phase stays in its own window
    function automatic logic [15:0] rand_pixel();
        int k;
        if (cfg_pick)
            k = $urandom_range(0, WIN_COUNT - 1);
        else
            k = cur_win;
        return win_value(k);
    endfunction

    // Unused fields of an item carry random values
    task automatic push_pixel(input logic [15:0] value);
        feed_item_t it;
        it.req_type = 1'b0;
        it.pixel = value;
        it.table_addr = 16'($urandom);
        it.table_data = 8'($urandom);
        pixel_feed.push_back(it);
    endtask

    task automatic push_twrite(input logic [15:0] addr, input logic [7:0] data);
        feed_item_t it;
        it.req_type = 1'b1;
        it.pixel = 16'($urandom);
        it.table_addr = addr;
        it.table_data = data;
        pixel_feed.push_back(it);
    endtask

    // Wait until every item is taken and every result is out, then let the pipe drain
    task automatic settle();
        while (pixel_feed.size() != 0 || req_valid || binned_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // Pixels still needed to reach the start of the next frame
    function automatic int frame_left();
        int w;
        int h;
        int cur_row;
        int rows_after;
        w = eff_width();
        h = eff_rows();
        if (col_idx == '0 && row_idx == '0)
            return 0;
        cur_row = (col_idx >= w - 1) ? 1 : w - int'(col_idx);
        rows_after = (row_idx >= h - 1) ? 0 : h - 1 - int'(row_idx);
        return cur_row + rows_after * w;
    endfunction

    task automatic cfg_write(input cfg_index_t idx, input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BIN_FACTOR: cfg_bin = value[2:0];
            CFG_PICK_MODE:  cfg_pick = value[0];
            CFG_ROW_WIDTH:  cfg_width = value;
            CFG_ROW_COUNT:  cfg_rows = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Go idle, finish the frame unless asked to keep the position, then load all registers
    task automatic start_phase(input logic [2:0] bin, input logic pick,
                               input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input bit keep);
        int n;
        logic [9:0]  junk_bin;
        logic [11:0] junk_pick;
        settle();
        if (!keep) begin
            n = frame_left();
            for (int i = 0; i < n; i++)
                push_pixel(rand_pixel());
            if (n > 0)
                settle();
        end
        junk_bin = 10'($urandom);
        junk_pick = 12'($urandom);
        // upper data bits above a narrow register are don't-care
        cfg_write(CFG_BIN_FACTOR, {junk_bin, bin});
        cfg_write(CFG_PICK_MODE, {junk_pick, pick});
        cfg_write(CFG_ROW_WIDTH, w);
        cfg_write(CFG_ROW_COUNT, h);
    endtask

    initial begin
        int rand_items;
        int n;
        int frames;
        logic [2:0] bin;
        logic pick;
        bit prev_pick;
        bit keep;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Windows at both ends of the range, around mid-scale, and one at random
        win_base[0] = 16'h0000;
        win_base[1] = 16'hFFF8;
        win_base[2] = 16'h7FFC;
        win_base[3] = 16'($urandom_range(0, 16'hFFF8));

        // Load every window back to back so no lookup ever hits an unwritten entry
        no_gaps <= 1'b1;
        for (int k = 0; k < WIN_COUNT; k++)
            for (int j = 0; j < WIN_SPAN; j++)
                push_twrite(win_base[k] + 16'(j), 8'($urandom));
        settle();
        no_gaps <= 1'b0;

        // Directed: one 4x4 average block of full-scale pixels gives the largest sums;
        // reload the entry it maps through just before the block completes
        start_phase(3'd4, 1'b0, 13'd4, 13'd4, 1'b0);
        cur_win = 1;
        for (int i = 0; i < 15; i++)
            push_pixel(16'hFFFF);
        push_twrite(16'hFFFF, 8'($urandom));
        push_pixel(16'hFFFF);

        // Directed: pick mode on a 3x3 frame keeps the partial blocks on both edges;
        // a table write right before the lookup that uses it
        start_phase(3'd2, 1'b1, 13'd3, 13'd3, 1'b0);
        push_twrite(16'h0000, 8'($urandom));
        push_pixel(16'h0000);
        push_pixel(rand_pixel());
        push_pixel(16'hFFFF);
        push_pixel(rand_pixel());
        push_pixel(rand_pixel());
        push_pixel(rand_pixel());
        push_pixel(16'h8000);
        push_pixel(rand_pixel());
        push_pixel(16'h7FFF);

        // Several block rows in average mode; squeeze the receiver meanwhile
        start_phase(3'd2, 1'b0, 13'd24, 13'd4, 1'b0);
        cur_win = $urandom_range(0, WIN_COUNT - 1);
        squeeze_reqs <= squeeze_reqs + 1;
        for (int i = 0; i < 24 * 4; i++)
            push_pixel(rand_pixel());

        // Out-of-range register values clamp: edge 7 acts as 4, width as 4096, count as 1;
        // stop part way through the row and carry on under the next sizes
        start_phase(3'd7, 1'b1, 13'h1FFF, 13'd0, 1'b0);
        for (int i = 0; i < 24; i++)
            push_pixel(rand_pixel());

        // Edge 0 acts as 2, width 0 as 1, count as 4096; the old column ends the row at once
        start_phase(3'd0, 1'b1, 13'd0, 13'h1FFF, 1'b1);
        for (int i = 0; i < 12; i++)
            push_pixel(rand_pixel());

        // Small pick frame: the old row position closes the frame at the first row end
        start_phase(3'd2, 1'b1, 13'd4, 13'd2, 1'b1);
        for (int i = 0; i < 4; i++)
            push_pixel(rand_pixel());

        // Random small frames; pick mode may stop mid-frame and carry on under new sizes
        rand_items = 0;
        prev_pick = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85)
                bin = 3'($urandom_range(2, 4));
            else
                bin = 3'($urandom_range(0, 7));
            pick = 1'($urandom_range(0, 1));
            w = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 12))
                                             : 13'($urandom_range(13, 24));
            h = 13'($urandom_range(1, 6));
            keep = prev_pick && pick;
            start_phase(bin, pick, w, h, keep);
            cur_win = $urandom_range(0, WIN_COUNT - 1);
            frames = $urandom_range(1, 2);
            n = frames * eff_width() * eff_rows();
            if (pick && $urandom_range(0, 99) < 30)
                n = $urandom_range(1, n);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 8) begin
                    push_twrite(win_value($urandom_range(0, WIN_COUNT - 1)), 8'($urandom));
                    rand_items++;
                end
                push_pixel(rand_pixel());
                rand_items++;
            end
            prev_pick = pick;
        end

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pblm_pkg.sv
hw/rtl/pblm_ram.sv
hw/rtl/pblm_scan.sv
hw/rtl/pblm_accum.sv
hw/rtl/pblm_map.sv
hw/rtl/pblm_fifo.sv
hw/rtl/pixel_bin_and_lut_map.sv
hw/rtl/pblm_checker.sv
test/pixel_bin_and_lut_map_tb.sv
